/* rtl/mcbf_pkg.sv */
// Shared sizes, codes, request and result types for the multi-channel byte FIFO.
package mcbf_pkg;

  localparam int NUM_CHANNELS = 16;
  localparam int FIFO_DEPTH   = 256;
  localparam int QUEUE_DEPTH  = 2;

  localparam int ACTION_W = 3;
  localparam int HANDLE_W = 5;
  localparam int STATUS_W = 3;
  localparam int TALLY_W  = 16;

  localparam int SLOT_W  = $clog2(NUM_CHANNELS);
  localparam int PTR_W   = (FIFO_DEPTH > 2) ? $clog2(FIFO_DEPTH) : 1;
  localparam int LVL_W   = $clog2(FIFO_DEPTH + 1);
  localparam int MEM_DEPTH = NUM_CHANNELS * FIFO_DEPTH;
  localparam int ADDR_W  = $clog2(MEM_DEPTH);
  localparam int CMP_W   = (HANDLE_W > SLOT_W + 1) ? HANDLE_W : SLOT_W + 1;

  localparam int HANDLE_OFFSET = 2;

  // Action codes on the request channel
  localparam logic [ACTION_W-1:0] ACT_CREATE = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_WRITE  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_READ   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_CLOSE  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOSLOT  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_REFUSED = 3'd5;

  typedef enum logic [2:0] {
    CMD_CREATE  = 3'd0,
    CMD_WRITE   = 3'd1,
    CMD_READ    = 3'd2,
    CMD_CLOSE   = 3'd3,
    CMD_CLEAR   = 3'd4,
    CMD_INVALID = 3'd5
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic              in_range;
    logic [SLOT_W-1:0] slot;
    logic [7:0]        data;
    logic              last;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] new_handle;
    logic [7:0]          read_byte;
    logic [TALLY_W-1:0]  bytes_done;
  } res_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [ADDR_W-1:0] mem_addr(input logic [SLOT_W-1:0] s,
                                                 input logic [PTR_W-1:0]  p);
    return ADDR_W'(s) * ADDR_W'(FIFO_DEPTH) + ADDR_W'(p);
  endfunction

endpackage

/* rtl/mcbf_front.sv */
// Front decode: classify the action and map the handle to a slot.
module mcbf_front (
  input  logic [mcbf_pkg::ACTION_W-1:0] action,
  input  logic [mcbf_pkg::HANDLE_W-1:0] handle,
  input  logic [7:0]                    data_byte,
  input  logic                          end_of_transfer,
  output mcbf_pkg::cmd_t                cmd
);
  import mcbf_pkg::*;

  logic [HANDLE_W-1:0] lowered;

  // Handles above the offset are lowered onto their slot
  assign lowered = (handle > HANDLE_W'(HANDLE_OFFSET)) ?
                   handle - HANDLE_W'(HANDLE_OFFSET) : handle;

  always_comb begin
    cmd.in_range = CMP_W'(handle) < CMP_W'(NUM_CHANNELS);
    cmd.slot     = SLOT_W'(lowered);
    cmd.data     = data_byte;
    cmd.last     = end_of_transfer;
    unique case (action)
      ACT_CREATE: cmd.kind = CMD_CREATE;
      ACT_WRITE:  cmd.kind = CMD_WRITE;
      ACT_READ:   cmd.kind = CMD_READ;
      ACT_CLOSE:  cmd.kind = CMD_CLOSE;
      ACT_CLEAR:  cmd.kind = CMD_CLEAR;
      default:    cmd.kind = CMD_INVALID;
    endcase
  end

endmodule

/* rtl/mcbf_cmd_queue.sv */
// Short request queue between the front decode and the back execution unit.
module mcbf_cmd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  mcbf_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop,
  output mcbf_pkg::cmd_t pop_cmd
);
  import mcbf_pkg::*;

  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t              entry [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = count != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_cmd    = entry[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/mcbf_back.sv */
// Back execution: channel pointers, byte store, transfer tally and result register.
module mcbf_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  mcbf_pkg::cmd_t q_cmd,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output mcbf_pkg::res_t res
);
  import mcbf_pkg::*;

  typedef enum logic [1:0] {
    BK_LOAD = 2'b01,
    BK_EXEC = 2'b10
  } bk_state_t;

  bk_state_t          state;
  bk_state_t          state_next;
  cmd_t               cmd;
  logic [7:0]         rd_data;
  logic [7:0]         mem [MEM_DEPTH];

  logic               slot_open [NUM_CHANNELS];
  logic [PTR_W-1:0]   head [NUM_CHANNELS];
  logic [PTR_W-1:0]   tail [NUM_CHANNELS];
  logic [LVL_W-1:0]   level [NUM_CHANNELS];
  logic [TALLY_W-1:0] tally;
  logic [TALLY_W-1:0] tally_next;
  logic [TALLY_W-1:0] tally_inc;

  logic               exec_fire;
  logic               free_found;
  logic [SLOT_W-1:0]  free_idx;
  logic               sel_open;
  logic [PTR_W-1:0]   hd;
  logic [PTR_W-1:0]   tl;
  logic [LVL_W-1:0]   lvl;
  logic               do_create;
  logic               do_empty;
  logic               do_close;
  logic               do_write;
  logic               do_read;
  res_t               res_next;

  assign q_pop     = (state == BK_LOAD) && q_valid;
  assign exec_fire = (state == BK_EXEC) && (!out_valid || out_ready);

  always_comb begin
    unique case (state)
      BK_LOAD: state_next = q_valid ? BK_EXEC : BK_LOAD;
      BK_EXEC: state_next = exec_fire ? BK_LOAD : BK_EXEC;
      default: state_next = BK_LOAD;
    endcase
  end

  // Lowest closed slot for create
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (!slot_open[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    sel_open  = cmd.in_range && slot_open[cmd.slot];
    hd        = head[cmd.slot];
    tl        = tail[cmd.slot];
    lvl       = level[cmd.slot];
    do_create = 1'b0;
    do_empty  = 1'b0;
    do_close  = 1'b0;
    do_write  = 1'b0;
    do_read   = 1'b0;
    tally_next = tally;
    res_next  = '0;
    res_next.status = ST_OK;
    unique case (cmd.kind)
      CMD_CREATE: begin
        if (free_found) begin
          do_create = 1'b1;
          res_next.new_handle = (free_idx == '0) ? '0 :
            HANDLE_W'({1'b0, free_idx} + (SLOT_W + 1)'(HANDLE_OFFSET));
        end else begin
          res_next.status = ST_NOSLOT;
        end
      end
      CMD_WRITE: begin
        if (!sel_open) begin
          res_next.status = ST_BAD;
        end else if (lvl >= LVL_W'(FIFO_DEPTH)) begin
          res_next.status = ST_FULL;
        end else begin
          do_write = 1'b1;
        end
      end
      CMD_READ: begin
        if (!sel_open) begin
          res_next.status = ST_BAD;
        end else if (lvl == '0) begin
          res_next.status = ST_EMPTY;
        end else begin
          do_read = 1'b1;
          res_next.read_byte = rd_data;
        end
      end
      CMD_CLOSE: begin
        if (!sel_open) begin
          res_next.status = ST_BAD;
        end else if (cmd.slot <= SLOT_W'(HANDLE_OFFSET)) begin
          res_next.status = ST_REFUSED;
        end else begin
          do_close = 1'b1;
          do_empty = 1'b1;
        end
      end
      CMD_CLEAR: begin
        if (!sel_open) begin
          res_next.status = ST_BAD;
        end else begin
          do_empty = 1'b1;
        end
      end
      default: res_next.status = ST_BAD;
    endcase

    // Count moved bytes, saturating; report and restart on the last byte
    tally_inc = ((do_write || do_read) && (tally != '1)) ? tally + 1'b1 : tally;
    if (cmd.kind == CMD_WRITE || cmd.kind == CMD_READ) begin
      if (cmd.last) begin
        res_next.bytes_done = tally_inc;
        tally_next = '0;
      end else begin
        tally_next = tally_inc;
      end
    end
  end

  // Byte store: read at load time, write at execute time
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_data <= mem[mem_addr(q_cmd.slot, head[q_cmd.slot])];
    end
    if (exec_fire && do_write) begin
      mem[mem_addr(cmd.slot, tl)] <= cmd.data;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd <= q_cmd;
    end
    if (exec_fire) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_LOAD;
      out_valid <= 1'b0;
      tally     <= '0;
      slot_open <= '{default: 1'b0};
      head      <= '{default: '0};
      tail      <= '{default: '0};
      level     <= '{default: '0};
    end else begin
      state <= state_next;
      if (exec_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (exec_fire) begin
        tally <= tally_next;
        if (do_create) begin
          slot_open[free_idx] <= 1'b1;
          head[free_idx]      <= '0;
          tail[free_idx]      <= '0;
          level[free_idx]     <= '0;
        end
        if (do_empty) begin
          head[cmd.slot]  <= '0;
          tail[cmd.slot]  <= '0;
          level[cmd.slot] <= '0;
        end
        if (do_close) begin
          slot_open[cmd.slot] <= 1'b0;
        end
        if (do_write) begin
          tail[cmd.slot]  <= ptr_inc(tl);
          level[cmd.slot] <= lvl + 1'b1;
        end
        if (do_read) begin
          head[cmd.slot]  <= ptr_inc(hd);
          level[cmd.slot] <= lvl - 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/multi_channel_byte_fifo.sv */
// Top level of the multi-channel byte FIFO: decode, request queue and execution unit.
//
// A set of byte FIFOs, one per slot, each a ring buffer with its own read
// index, write index and fill level, sharing one byte store. Every request
// names one action (create, write a byte, read a byte, close, clear) and
// returns exactly one result, in request order. Create hands out handle 0
// for slot 0 and slot+2 for the others; other actions drop handles out of
// range or naming a closed slot with a bad-handle status. A write to a full
// FIFO or a read from an empty one does not block: it answers full or empty.
// Writes and reads count moved bytes (saturating at 65535); the write or
// read marked end_of_transfer reports that count and restarts it. The front
// decodes each request into a two-entry queue, so requests are taken while
// the back is busy. The back handles each request in a load state
// that pops the queue and reads the byte store at the channel's read index,
// then an execute state that updates the channel's pointers, writes the
// store and loads the result register. The back takes no new request until
// the last one is through; this is set by the store's single registered read
// followed by the pointer update. A result that is not taken holds the back
// in its execute state; the queue keeps accepting until it is full. A
// request passes through the queue, the load state and the execute state
// before its result is offered. Reset clears all channel state at once; the
// byte store needs no clearing pass.
module multi_channel_byte_fifo (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mcbf_pkg::ACTION_W-1:0] action,
  input  logic [mcbf_pkg::HANDLE_W-1:0] handle,
  input  logic [7:0]                    data_byte,
  input  logic                          end_of_transfer,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mcbf_pkg::STATUS_W-1:0] status,
  output logic [mcbf_pkg::HANDLE_W-1:0] new_handle,
  output logic [7:0]                    read_byte,
  output logic [mcbf_pkg::TALLY_W-1:0]  bytes_done
);
  import mcbf_pkg::*;

  cmd_t front_cmd;
  cmd_t q_cmd;
  logic q_valid;
  logic q_pop;
  res_t res;

  // Classify the incoming request
  mcbf_front u_front (
    .action          (action),
    .handle          (handle),
    .data_byte       (data_byte),
    .end_of_transfer (end_of_transfer),
    .cmd             (front_cmd)
  );

  // Hold decoded requests until the back is free
  mcbf_cmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_cmd   (front_cmd),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_cmd    (q_cmd)
  );

  // Carry out each request in a load state and then an execute state
  mcbf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign status     = res.status;
  assign new_handle = res.new_handle;
  assign read_byte  = res.read_byte;
  assign bytes_done = res.bytes_done;

  // The back never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("request popped from empty queue");

  // The back does not pop the queue again in the cycle after a pop
  a_pop_then_busy: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> !q_pop)
    else $error("back popped two requests in a row");

  // A handle is only given out with an ok status
  a_handle_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && (new_handle != '0) |-> status == ST_OK)
    else $error("handle reported on a failed request");

  // A byte is only returned with an ok status
  a_byte_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && (read_byte != '0) |-> status == ST_OK)
    else $error("byte reported on a failed request");

endmodule
